// File: hw/rtl/euc_jp_to_shift_jis_unit_defines.svh
// Assertion macros used by the EUC-JP to Shift-JIS converter top level.
`ifndef EUC_JP_TO_SHIFT_JIS_UNIT_DEFINES_SVH
`define EUC_JP_TO_SHIFT_JIS_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define EJ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define EJ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ejsj_pkg.sv
// Types, constants and the half-width kana table for the EUC-JP to Shift-JIS converter.
package ejsj_pkg;

    localparam logic [7:0] DBL_LO     = 8'ha1;
    localparam logic [7:0] DBL_HI     = 8'hfe;
    localparam logic [7:0] KANA_LO    = 8'ha1;
    localparam logic [7:0] KANA_HI    = 8'hdf;
    localparam logic [7:0] SS2_BYTE   = 8'h8e;
    localparam logic [7:0] HIGH_BIT   = 8'h80;
    localparam logic [7:0] ROW_SPLIT  = 8'h5f;
    localparam logic [7:0] CELL_SPLIT = 8'h5f;
    localparam logic [7:0] BAND_HI    = 8'hb0;
    localparam logic [7:0] BAND_LO    = 8'h70;
    localparam logic [7:0] STEP_ODD_HI = 8'h20;
    localparam logic [7:0] STEP_ODD_LO = 8'h1f;
    localparam logic [7:0] STEP_EVEN  = 8'h7e;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_LEAD  = 2'd1,
        MODE_SHIFT = 2'd2
    } mode_t;

    // Converter state held between bytes.
    typedef struct packed {
        mode_t      mode;
        logic [7:0] held;
    } conv_state_t;

    // Everything one input byte produces.
    typedef struct packed {
        logic [1:0]  count;   // 0, 1 or 2 output bytes
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        conv_state_t state;
    } conv_res_t;

    // One queued output byte with its flags.
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       text_end;
    } out_item_t;

    // Full-width Shift-JIS pair {lead, trail} for half-width kana 0xA1 + idx.
    function automatic logic [15:0] wide_kana(input logic [5:0] idx);
        logic [15:0] w;
        case (idx)
            6'd0:  w = 16'h8142;  6'd1:  w = 16'h8175;  6'd2:  w = 16'h8176;
            6'd3:  w = 16'h8141;  6'd4:  w = 16'h8145;  6'd5:  w = 16'h8392;
            6'd6:  w = 16'h8340;  6'd7:  w = 16'h8342;  6'd8:  w = 16'h8344;
            6'd9:  w = 16'h8346;  6'd10: w = 16'h8348;  6'd11: w = 16'h8383;
            6'd12: w = 16'h8385;  6'd13: w = 16'h8387;  6'd14: w = 16'h8362;
            6'd15: w = 16'h815b;  6'd16: w = 16'h8341;  6'd17: w = 16'h8343;
            6'd18: w = 16'h8345;  6'd19: w = 16'h8347;  6'd20: w = 16'h8349;
            6'd21: w = 16'h834a;  6'd22: w = 16'h834c;  6'd23: w = 16'h834e;
            6'd24: w = 16'h8350;  6'd25: w = 16'h8352;  6'd26: w = 16'h8354;
            6'd27: w = 16'h8356;  6'd28: w = 16'h8358;  6'd29: w = 16'h835a;
            6'd30: w = 16'h835c;  6'd31: w = 16'h835e;  6'd32: w = 16'h8360;
            6'd33: w = 16'h8363;  6'd34: w = 16'h8365;  6'd35: w = 16'h8367;
            6'd36: w = 16'h8369;  6'd37: w = 16'h836a;  6'd38: w = 16'h836b;
            6'd39: w = 16'h836c;  6'd40: w = 16'h836d;  6'd41: w = 16'h836e;
            6'd42: w = 16'h8371;  6'd43: w = 16'h8374;  6'd44: w = 16'h8377;
            6'd45: w = 16'h837a;  6'd46: w = 16'h837d;  6'd47: w = 16'h837e;
            6'd48: w = 16'h8380;  6'd49: w = 16'h8381;  6'd50: w = 16'h8382;
            6'd51: w = 16'h8384;  6'd52: w = 16'h8386;  6'd53: w = 16'h8388;
            6'd54: w = 16'h8389;  6'd55: w = 16'h838a;  6'd56: w = 16'h838b;
            6'd57: w = 16'h838c;  6'd58: w = 16'h838d;  6'd59: w = 16'h838f;
            6'd60: w = 16'h8393;  6'd61: w = 16'h814a;  6'd62: w = 16'h814b;
            default: w = 16'h0000;
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/euc_jp_to_shift_jis_unit.sv
// Top level of the EUC-JP to Shift-JIS byte-stream converter.
//
// Input stream (s_*): one EUC-JP byte per transaction in s_tdata, s_tlast marks
// the last byte of a text. Output stream (m_*): one Shift-JIS byte per
// transaction in m_tdata; m_tuser is high on the last byte caused by one input
// byte, m_tlast on the last byte of the whole text. A lead byte produces no
// output until its trail arrives or the text ends; then two bytes may follow.
// cfg_wen/cfg_wdata write want_zen (widen half-width kana); write it only
// while the stream is idle.
// Path: a byte accepted on s_* lands in the input register, is decoded into
// the output queue once the queue can take it, and its first result is offered
// from there on. Throughput is one input byte per cycle while each makes at most
// one output byte and m_tready is high; a two-byte input holds the single-byte
// output port while both drain, so the queue's draining sets the rate.
// Reset clears the input register, the output queue, the held lead byte and
// want_zen. When m_tready is low the queue holds; s_tready drops once the
// input register is full and cannot be decoded into the queue.
`include "euc_jp_to_shift_jis_unit_defines.svh"

module euc_jp_to_shift_jis_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic       cfg_wdata,     // want_zen
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] in_byte
    input  logic       s_tlast,       // text_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [7:0] out_byte
    output logic       m_tuser,       // [0] run_last
    output logic       m_tlast        // text_end
);
    import ejsj_pkg::*;

    logic        want_zen_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    conv_state_t state_reg;
    conv_state_t state_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    out_item_t   q0_reg;
    out_item_t   q0_next;
    out_item_t   q1_reg;
    out_item_t   q1_next;
    conv_res_t   res;
    logic        out_fire;
    logic        load_ok;
    logic        consume;
    logic        load;

    ejsj_conv u_conv (
        .cur       (state_reg),
        .in_byte   (in_byte_reg),
        .text_last (in_last_reg),
        .want_zen  (want_zen_reg),
        .res       (res)
    );

    assign out_fire = m_tvalid && m_tready;
    // the queue can take a fresh pair once it is empty or about to be
    assign load_ok  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign consume  = in_valid_reg && ((res.count == 2'd0) || load_ok);
    assign load     = consume && (res.count != 2'd0);
    assign s_tready = !in_valid_reg || consume;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = q0_reg.data;
    assign m_tuser  = q0_reg.run_last;
    assign m_tlast  = q0_reg.text_end;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        if (consume)
        begin
            state_next = res.state;
        end
        if (load)
        begin
            cnt_next         = res.count;
            q0_next.data     = res.byte0;
            q0_next.run_last = (res.count == 2'd1);
            q0_next.text_end = (res.count == 2'd1) && in_last_reg;
            q1_next.data     = res.byte1;
            q1_next.run_last = 1'b1;
            q1_next.text_end = in_last_reg;
        end
        else if (out_fire)
        begin
            cnt_next = cnt_reg - 2'd1;
            q0_next  = q1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_zen_reg   <= 1'b0;
            in_valid_reg   <= 1'b0;
            state_reg.mode <= MODE_IDLE;
            state_reg.held <= 8'h00;
            cnt_reg        <= 2'd0;
        end
        else
        begin
            if (cfg_wen)
            begin
                want_zen_reg <= cfg_wdata;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    `EJ_ASSERT_NOW(a_pair_head_not_last, cnt_reg == 2'd2, !q0_reg.run_last,
        "first byte of a queued pair flagged as run end")
    `EJ_ASSERT_NOW(a_text_end_ends_run, m_tvalid && m_tlast, m_tuser,
        "text end on a byte that does not end its run")
    `EJ_ASSERT_NEXT(a_last_clears_mode, consume && in_last_reg,
        state_reg.mode == MODE_IDLE, "pending state survives end of text")
    `EJ_ASSERT_NOW(a_stall_needs_full, !s_tready, in_valid_reg && (cnt_reg != 2'd0),
        "input stalled with room to decode")

endmodule

// File: hw/rtl/ejsj_conv.sv
// Byte decoder: EUC-JP byte plus held state to zero, one or two Shift-JIS bytes.
module ejsj_conv (
    input  ejsj_pkg::conv_state_t cur,
    input  logic [7:0]            in_byte,
    input  logic                  text_last,
    input  logic                  want_zen,
    output ejsj_pkg::conv_res_t   res
);
    import ejsj_pkg::*;

    logic        b_dbl;
    logic        b_kana;
    logic        b_ss2;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [7:0]  band;
    logic [7:0]  step;
    logic [7:0]  row_half;
    logic [7:0]  sj_hi;
    logic [7:0]  sj_lo;
    logic [5:0]  kana_idx;
    logic [7:0]  kana_off;
    logic [15:0] kana_pair;

    assign b_dbl  = (in_byte >= DBL_LO) && (in_byte <= DBL_HI);
    assign b_kana = (in_byte >= KANA_LO) && (in_byte <= KANA_HI);
    assign b_ss2  = (in_byte == SS2_BYTE);

    // JIS row/cell to Shift-JIS
    assign row      = cur.held - HIGH_BIT;
    assign col      = in_byte - HIGH_BIT;
    assign band     = (row >= ROW_SPLIT) ? BAND_HI : BAND_LO;
    assign step     = row[0] ? ((col > CELL_SPLIT) ? STEP_ODD_HI : STEP_ODD_LO) : STEP_EVEN;
    assign row_half = (row + 8'd1) >> 1;
    assign sj_hi    = row_half + band;
    assign sj_lo    = col + step;

    assign kana_off  = in_byte - KANA_LO;
    assign kana_idx  = kana_off[5:0];
    assign kana_pair = wide_kana(kana_idx);

    always_comb
    begin
        res.count      = 2'd0;
        res.byte0      = in_byte;
        res.byte1      = in_byte;
        res.state.mode = MODE_IDLE;
        res.state.held = cur.held;
        case (cur.mode)
            MODE_LEAD:
            begin
                res.count = 2'd2;
                if (b_dbl)
                begin
                    res.byte0 = sj_hi;
                    res.byte1 = sj_lo;
                end
                else
                begin
                    res.byte0 = cur.held;
                end
            end
            MODE_SHIFT:
            begin
                if (b_kana)
                begin
                    if (want_zen)
                    begin
                        res.count = 2'd2;
                        res.byte0 = kana_pair[15:8];
                        res.byte1 = kana_pair[7:0];
                    end
                    else
                    begin
                        res.count = 2'd1;
                    end
                end
                else
                begin
                    res.count = 2'd2;
                    res.byte0 = SS2_BYTE;
                end
            end
            default:
            begin
                if (b_dbl || b_ss2)
                begin
                    if (text_last)
                    begin
                        // lead at end of text: pretend a NUL trail follows
                        res.count = 2'd2;
                        res.byte1 = 8'h00;
                    end
                    else
                    begin
                        res.state.held = in_byte;
                        res.state.mode = b_dbl ? MODE_LEAD : MODE_SHIFT;
                    end
                end
                else
                begin
                    res.count = 2'd1;
                end
            end
        endcase
        if (text_last)
        begin
            res.state.mode = MODE_IDLE;
        end
    end

endmodule
